/* hw/rtl/dlcaf_pkg.sv */
// Package for the dual load-cell adaptive filter: default sizes, register
// indexes, mode codes and the structs that pass between the control and lanes.
// No dependencies.
package dlcaf_pkg;

  localparam int RING_DEPTH_DEF    = 16;
  localparam int MEDIAN_TAPS_DEF   = 5;
  localparam int MEAN_TAPS_DEF     = 8;
  localparam int SPREAD_WINDOW_DEF = 16;

  localparam int SAMPLE_W = 24;
  localparam int CFG_DW   = 31;

  localparam logic [1:0] CFG_ACTIVITY = 2'd0;
  localparam logic [1:0] CFG_JUMP     = 2'd1;
  localparam logic [1:0] CFG_QUIET    = 2'd2;

  localparam logic [15:0] ACTIVITY_RST = 16'd50;
  localparam logic [19:0] JUMP_RST     = 20'd2000;
  localparam logic [30:0] QUIET_RST    = 31'd1000;

  localparam logic [1:0] MODE_STABLE        = 2'd0;
  localparam logic [1:0] MODE_BREWING       = 2'd1;
  localparam logic [1:0] MODE_TRANSITIONING = 2'd2;
  localparam logic [1:0] MODE_UNUSED        = 2'd3;

  typedef struct packed {
    logic                       start;
    logic                       refill;
    logic                       brew;
    logic signed [SAMPLE_W-1:0] sample;
  } lane_cmd_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] filtered;
    logic [SAMPLE_W-1:0]        spread;
  } lane_rsp_t;

endpackage

/* hw/rtl/dlcaf_in_if.sv */
// Sample channel of the dual load-cell adaptive filter.
// Carries valid, ready and one pair of readings with a time stamp.
interface dlcaf_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] ch1_weight;
  logic signed [23:0] ch2_weight;
  logic [31:0]        now_ms;

  modport source (output valid, ch1_weight, ch2_weight, now_ms, input ready);
  modport sink   (input valid, ch1_weight, ch2_weight, now_ms, output ready);
endinterface

/* hw/rtl/dlcaf_out_if.sv */
// Result channel of the dual load-cell adaptive filter.
// Carries valid, ready and one filtered result.
interface dlcaf_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] total_filtered;
  logic signed [23:0] ch1_filtered;
  logic signed [23:0] ch2_filtered;
  logic [23:0]        ch1_spread;
  logic [23:0]        ch2_spread;
  logic [1:0]         filter_mode;

  modport source (output valid, total_filtered, ch1_filtered, ch2_filtered,
                  ch1_spread, ch2_spread, filter_mode, input ready);
  modport sink   (input valid, total_filtered, ch1_filtered, ch2_filtered,
                  ch1_spread, ch2_spread, filter_mode, output ready);
endinterface

/* hw/rtl/dlcaf_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses nothing from the package.
module dlcaf_div #(
  parameter int NW = 58,
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsr;
  logic [NW-1:0]   q;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {rem, q[NW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
        rem  <= '0;
        q    <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem  <= fits ? DW'(trial - {1'b0, dsr}) : DW'(trial);
        q    <= {q[NW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;
endmodule

/* hw/rtl/dlcaf_isqrt.sv */
// Floor integer square root, one result bit per cycle.
// Uses nothing from the package.
module dlcaf_isqrt #(
  parameter int W = 58
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [W-1:0]   value,
  output logic           done,
  output logic [W/2-1:0] root
);
  localparam int CNTW = $clog2(W / 2 + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]    v;
  logic [W-1:0]    r;
  logic [W-1:0]    b;
  logic [W-1:0]    t;

  assign t = r + b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W / 2);
        v    <= value;
        r    <= '0;
        b    <= W'(1) << (W - 2);
      end else if (busy) begin
        if (v >= t) begin
          v <= v - t;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b   <= b >> 2;
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = r[W/2-1:0];
endmodule

/* hw/rtl/dlcaf_lane.sv */
// One channel lane: sample ring, median or mean filter, output history and
// spread. Depends on dlcaf_pkg, dlcaf_div and dlcaf_isqrt.
module dlcaf_lane
  import dlcaf_pkg::*;
#(
  parameter int RING_DEPTH    = RING_DEPTH_DEF,
  parameter int MEDIAN_TAPS   = MEDIAN_TAPS_DEF,
  parameter int MEAN_TAPS     = MEAN_TAPS_DEF,
  parameter int SPREAD_WINDOW = SPREAD_WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  lane_cmd_t cmd,
  output lane_rsp_t rsp
);
  localparam int RAW   = $clog2(RING_DEPTH);
  localparam int SFW   = $clog2(RING_DEPTH + 1);
  localparam int MED_N = (MEDIAN_TAPS > RING_DEPTH) ? RING_DEPTH : MEDIAN_TAPS;
  localparam int MEAN_N = (MEAN_TAPS > RING_DEPTH) ? RING_DEPTH : MEAN_TAPS;
  localparam int TAP_N = (MED_N > MEAN_N) ? MED_N : MEAN_N;
  localparam int KW    = $clog2(TAP_N + 1);
  localparam int CW    = (MED_N > 1) ? $clog2(MED_N) : 1;
  localparam int CNTW  = $clog2(MED_N + 1);
  localparam int MID   = MED_N / 2;
  localparam int SMW   = SAMPLE_W + $clog2(MEAN_N + 1);
  localparam int MLW   = $clog2(MEAN_N);
  localparam int RSH   = SMW + MLW;
  localparam longint unsigned MREC =
    ((64'd1 << RSH) + 64'(MEAN_N) - 64'd1) / 64'(MEAN_N);
  localparam int HAW   = $clog2(SPREAD_WINDOW);
  localparam int HFW   = $clog2(SPREAD_WINDOW + 1);
  localparam int BW    = $clog2(HFW);
  localparam int S1W   = SAMPLE_W + HFW;
  localparam int S2W   = 2 * SAMPLE_W - 1 + HFW;
  localparam int NUMW  = 2 * SAMPLE_W + 2 * HFW;
  localparam int DVW   = 2 * HFW + 5;
  localparam int RW    = NUMW / 2;

  typedef enum logic [9:0] {
    L_IDLE = 10'b0000000001,
    L_TAP  = 10'b0000000010,
    L_MED  = 10'b0000000100,
    L_MDIV = 10'b0000001000,
    L_REC  = 10'b0000010000,
    L_SUM  = 10'b0000100000,
    L_NMUL = 10'b0001000000,
    L_SUB  = 10'b0010000000,
    L_SDIV = 10'b0100000000,
    L_ROOT = 10'b1000000000
  } lane_state_t;

  lane_state_t st;

  // Sample ring; entries older than the last refill read as the fill value.
  logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] ring_q;
  logic [RAW-1:0]             ptr;
  logic [RAW-1:0]             raddr;
  logic [SFW-1:0]             since;
  logic signed [SAMPLE_W-1:0] fill_val;
  logic                       brew;

  logic [KW-1:0]              k;
  logic [KW-1:0]              pk;
  logic                       pv;
  logic [KW-1:0]              n_taps;
  logic signed [SAMPLE_W-1:0] tap_v;
  logic signed [SAMPLE_W-1:0] taps [MED_N];
  logic [CW-1:0]              c;
  logic signed [SMW-1:0]      sum;
  logic signed [SMW-1:0]      sum_nx;
  logic [SMW-1:0]             smag;
  logic                       sneg;
  logic [CNTW-1:0]            nlt;
  logic [CNTW-1:0]            neq;
  logic                       is_med;
  logic [2*SMW:0]             mean_prod;
  logic [SAMPLE_W-1:0]        mean_q;

  logic signed [SAMPLE_W-1:0] hist [SPREAD_WINDOW];
  logic signed [SAMPLE_W-1:0] hist_q;
  logic [HAW-1:0]             hp;
  logic [HFW-1:0]             fill;
  logic [HFW-1:0]             fill_n;
  logic [HFW-1:0]             i;
  logic                       hp1;
  logic                       hp2;
  logic [S2W-2:0]             sq;
  logic signed [S1W-1:0]      s1;
  logic [S2W-1:0]             s2;
  logic [S1W-1:0]             mag1;
  logic [NUMW-1:0]            sqs1;
  logic [NUMW-1:0]            nprod;
  logic [BW-1:0]              b;

  logic signed [SAMPLE_W-1:0] res;
  logic [SAMPLE_W-1:0]        spread;
  logic                       res_valid;

  logic                       div_go;
  logic [NUMW-1:0]            div_a;
  logic [DVW-1:0]             div_b;
  logic                       div_done;
  logic [NUMW-1:0]            div_q;
  logic                       root_go;
  logic                       root_done;
  logic [RW-1:0]              root;

  dlcaf_div #(.NW(NUMW), .DW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  dlcaf_isqrt #(.W(NUMW)) u_root (
    .clk   (clk),
    .rst   (rst),
    .go    (root_go),
    .value (div_a),
    .done  (root_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (st == L_IDLE && cmd.start && !cmd.refill) begin
      ring[ptr] <= cmd.sample;
    end
    ring_q <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (st == L_REC) begin
      hist[hp] <= res;
    end
    hist_q <= hist[i[HAW-1:0]];
  end

  assign n_taps = brew ? KW'(MED_N) : KW'(MEAN_N);
  assign tap_v  = (8'(pk) < 8'(since)) ? ring_q : fill_val;
  assign sum_nx = sum + SMW'(tap_v);
  assign smag   = sum_nx[SMW-1] ? SMW'(-sum_nx) : SMW'(sum_nx);
  assign fill_n = (fill == HFW'(SPREAD_WINDOW)) ? fill : HFW'(fill + 1'b1);
  assign mag1   = s1[S1W-1] ? S1W'(-s1) : S1W'(s1);

  // The tap count divides the magnitude of the sum through a multiplication by
  // its rounded-up reciprocal, which is exact over the whole range of the sum.
  assign mean_prod = div_a[SMW-1:0] * (SMW + 1)'(MREC);
  assign mean_q    = mean_prod[RSH +: SAMPLE_W];

  always_comb begin
    nlt = '0;
    neq = '0;
    for (int j = 0; j < MED_N; j++) begin
      nlt = nlt + CNTW'(taps[j] < taps[c]);
      neq = neq + CNTW'(taps[j] == taps[c]);
    end
    is_med = (nlt <= CNTW'(MID)) && ((CNTW + 1)'(MID) < (CNTW + 1)'(nlt) + (CNTW + 1)'(neq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= L_IDLE;
      ptr       <= '0;
      since     <= '0;
      hp        <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
      div_go    <= 1'b0;
      root_go   <= 1'b0;
      pv        <= 1'b0;
      hp1       <= 1'b0;
      hp2       <= 1'b0;
    end else begin
      div_go  <= 1'b0;
      root_go <= 1'b0;
      unique case (st)
        L_IDLE: begin
          if (cmd.start) begin
            res_valid <= 1'b0;
            brew      <= cmd.brew;
            if (cmd.refill) begin
              fill_val <= cmd.sample;
              since    <= '0;
              ptr      <= '0;
              res      <= cmd.sample;
              st       <= L_REC;
            end else begin
              ptr   <= (ptr == RAW'(RING_DEPTH - 1)) ? '0 : RAW'(ptr + 1'b1);
              since <= (since == SFW'(RING_DEPTH)) ? since : SFW'(since + 1'b1);
              raddr <= ptr;
              k     <= '0;
              pv    <= 1'b0;
              sum   <= '0;
              st    <= L_TAP;
            end
          end
        end
        L_TAP: begin
          pv <= k < n_taps;
          pk <= k;
          if (k < n_taps) begin
            k     <= KW'(k + 1'b1);
            raddr <= (raddr == '0) ? RAW'(RING_DEPTH - 1) : RAW'(raddr - 1'b1);
          end
          if (pv) begin
            if (brew) begin
              taps[pk[CW-1:0]] <= tap_v;
            end else begin
              sum <= sum_nx;
            end
            if (pk == KW'(n_taps - 1'b1)) begin
              pv <= 1'b0;
              c  <= '0;
              if (brew) begin
                st <= L_MED;
              end else begin
                div_a <= NUMW'(smag);
                sneg  <= sum_nx[SMW-1];
                st    <= L_MDIV;
              end
            end
          end
        end
        L_MED: begin
          if (is_med) begin
            res <= taps[c];
            st  <= L_REC;
          end else begin
            c <= CW'(c + 1'b1);
          end
        end
        L_MDIV: begin
          res <= sneg ? SAMPLE_W'(-mean_q) : mean_q;
          st  <= L_REC;
        end
        L_REC: begin
          hp   <= (hp == HAW'(SPREAD_WINDOW - 1)) ? '0 : HAW'(hp + 1'b1);
          fill <= fill_n;
          if (fill_n < HFW'(2)) begin
            spread    <= '0;
            res_valid <= 1'b1;
            st        <= L_IDLE;
          end else begin
            i   <= '0;
            hp1 <= 1'b0;
            hp2 <= 1'b0;
            s1  <= '0;
            s2  <= '0;
            st  <= L_SUM;
          end
        end
        L_SUM: begin
          // Read, square and accumulate as three overlapped steps.
          hp1 <= i < fill;
          if (i < fill) begin
            i <= HFW'(i + 1'b1);
          end
          hp2 <= hp1;
          if (hp1) begin
            s1 <= s1 + S1W'(hist_q);
            sq <= (S2W - 1)'(hist_q * hist_q);
          end
          if (hp2) begin
            s2 <= s2 + S2W'(sq);
          end
          if (i == fill && !hp1 && !hp2) begin
            b     <= '0;
            nprod <= '0;
            st    <= L_NMUL;
          end
        end
        L_NMUL: begin
          // n times the sum of squares by shift and add over the bits of n.
          if (fill[b]) begin
            nprod <= nprod + (NUMW'(s2) << b);
          end
          sqs1 <= NUMW'(mag1 * mag1);
          if (b == BW'(HFW - 1)) begin
            st <= L_SUB;
          end else begin
            b <= BW'(b + 1'b1);
          end
        end
        L_SUB: begin
          div_a  <= (nprod >= sqs1) ? NUMW'(nprod - sqs1) : '0;
          div_b  <= DVW'(fill * (fill - 1'b1));
          div_go <= 1'b1;
          st     <= L_SDIV;
        end
        L_SDIV: begin
          if (div_done) begin
            div_a   <= div_q;
            root_go <= 1'b1;
            st      <= L_ROOT;
          end
        end
        L_ROOT: begin
          if (root_done) begin
            spread    <= (root > RW'(24'hFFFFFF)) ? 24'hFFFFFF : root[SAMPLE_W-1:0];
            res_valid <= 1'b1;
            st        <= L_IDLE;
          end
        end
        default: st <= L_IDLE;
      endcase
    end
  end

  assign rsp.valid    = res_valid;
  assign rsp.filtered = res;
  assign rsp.spread   = spread;
endmodule

/* hw/rtl/dual_load_cell_adaptive_filter.sv */
// Dual load-cell adaptive filter. Each sample transfer carries two signed
// readings in 0.01 g and a millisecond stamp, and yields exactly one result
// transfer. The block works on one sample at a time: with default sizes and a
// full output history, the time from a sample's transfer to a loaded result is
// set mostly by the bit-serial divider for the variance (one bit per cycle over
// a 58-bit dividend) and the 29-step square root, in any mode; the mean divides
// by a reciprocal multiplication. The first sample after reset skips the filter
// and the spread.
// A finished result waits in the output register while the next sample is
// taken. There is no clearing pass after reset.
// Depends on dlcaf_pkg, the two channel interfaces and dlcaf_lane.
module dual_load_cell_adaptive_filter
  import dlcaf_pkg::*;
#(
  parameter int RING_DEPTH    = RING_DEPTH_DEF,
  parameter int MEDIAN_TAPS   = MEDIAN_TAPS_DEF,
  parameter int MEAN_TAPS     = MEAN_TAPS_DEF,
  parameter int SPREAD_WINDOW = SPREAD_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  dlcaf_in_if.sink          samples,
  dlcaf_out_if.source       filtered
);
  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_HOLD = 3'b100
  } ctrl_state_t;

  ctrl_state_t st;

  logic [15:0]                activity_threshold;
  logic [19:0]                jump_threshold;
  logic [30:0]                quiet_timeout_ms;

  logic                       primed;
  logic [1:0]                 mode;
  logic [31:0]                last_activity_ms;
  logic signed [SAMPLE_W-1:0] held1;
  logic signed [SAMPLE_W-1:0] held2;

  logic                       accept;
  logic signed [25:0]         diff;
  logic [25:0]                change;
  logic                       active;
  logic                       jump;
  logic [31:0]                quiet;
  logic                       quiet1;
  logic                       quiet2;
  logic [1:0]                 mode_rule;
  logic [1:0]                 mode_next;
  logic                       touch;
  logic                       touch_next;

  lane_cmd_t                  cmd1;
  lane_cmd_t                  cmd2;
  lane_rsp_t                  rsp1;
  lane_rsp_t                  rsp2;

  logic                       out_valid;
  logic                       out_free;
  logic                       load;
  logic signed [24:0]         out_total;
  logic signed [SAMPLE_W-1:0] out_ch1;
  logic signed [SAMPLE_W-1:0] out_ch2;
  logic [SAMPLE_W-1:0]        out_sp1;
  logic [SAMPLE_W-1:0]        out_sp2;
  logic [1:0]                 out_mode;

  assign samples.ready = (st == C_IDLE);
  assign accept        = samples.valid && samples.ready;

  assign diff   = (26'(samples.ch1_weight) + 26'(samples.ch2_weight)) -
                  (26'(held1) + 26'(held2));
  assign change = diff[25] ? 26'(-diff) : 26'(diff);
  assign active = change > {10'b0, activity_threshold};
  assign jump   = primed && (change > {6'b0, jump_threshold});
  assign quiet  = samples.now_ms - last_activity_ms;
  assign quiet1 = quiet > {1'b0, quiet_timeout_ms};
  assign quiet2 = {1'b0, quiet} > {1'b0, quiet_timeout_ms, 1'b0};

  always_comb begin
    mode_rule = mode;
    touch     = 1'b0;
    case (mode)
      MODE_STABLE: begin
        if (active) begin
          mode_rule = MODE_BREWING;
          touch     = 1'b1;
        end
      end
      MODE_BREWING: begin
        if (active) begin
          touch = 1'b1;
        end else if (quiet1) begin
          mode_rule = MODE_TRANSITIONING;
        end
      end
      default: begin
        // The unused code behaves as transitioning.
        if (active) begin
          mode_rule = MODE_BREWING;
          touch     = 1'b1;
        end else if (quiet2) begin
          mode_rule = MODE_STABLE;
        end
      end
    endcase
    mode_next  = mode_rule;
    touch_next = touch;
    if (jump && mode_rule == MODE_STABLE) begin
      mode_next  = MODE_BREWING;
      touch_next = 1'b1;
    end
    if (!primed) begin
      mode_next  = mode;
      touch_next = 1'b0;
    end
  end

  assign cmd1.start  = accept;
  assign cmd1.refill = !primed || jump;
  assign cmd1.brew   = (mode_rule == MODE_BREWING);
  assign cmd1.sample = samples.ch1_weight;
  assign cmd2.start  = accept;
  assign cmd2.refill = !primed || jump;
  assign cmd2.brew   = (mode_rule == MODE_BREWING);
  assign cmd2.sample = samples.ch2_weight;

  dlcaf_lane #(
    .RING_DEPTH    (RING_DEPTH),
    .MEDIAN_TAPS   (MEDIAN_TAPS),
    .MEAN_TAPS     (MEAN_TAPS),
    .SPREAD_WINDOW (SPREAD_WINDOW)
  ) u_lane1 (
    .clk (clk),
    .rst (rst),
    .cmd (cmd1),
    .rsp (rsp1)
  );

  dlcaf_lane #(
    .RING_DEPTH    (RING_DEPTH),
    .MEDIAN_TAPS   (MEDIAN_TAPS),
    .MEAN_TAPS     (MEAN_TAPS),
    .SPREAD_WINDOW (SPREAD_WINDOW)
  ) u_lane2 (
    .clk (clk),
    .rst (rst),
    .cmd (cmd2),
    .rsp (rsp2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      activity_threshold <= ACTIVITY_RST;
      jump_threshold     <= JUMP_RST;
      quiet_timeout_ms   <= QUIET_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_ACTIVITY: activity_threshold <= cfg_data[15:0];
        CFG_JUMP:     jump_threshold     <= cfg_data[19:0];
        CFG_QUIET:    quiet_timeout_ms   <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign out_free = !out_valid || filtered.ready;
  assign load     = ((st == C_RUN && rsp1.valid && rsp2.valid) || st == C_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= C_IDLE;
      primed           <= 1'b0;
      mode             <= MODE_STABLE;
      last_activity_ms <= '0;
      held1            <= '0;
      held2            <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        primed <= 1'b1;
        mode   <= mode_next;
        if (touch_next) begin
          last_activity_ms <= samples.now_ms;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
        out_total <= 25'(rsp1.filtered) + 25'(rsp2.filtered);
        out_ch1   <= rsp1.filtered;
        out_ch2   <= rsp2.filtered;
        out_sp1   <= rsp1.spread;
        out_sp2   <= rsp2.spread;
        out_mode  <= mode;
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        C_IDLE: begin
          if (accept) begin
            st <= C_RUN;
          end
        end
        C_RUN: begin
          if (rsp1.valid && rsp2.valid) begin
            held1 <= rsp1.filtered;
            held2 <= rsp2.filtered;
            st    <= load ? C_IDLE : C_HOLD;
          end
        end
        C_HOLD: begin
          if (load) begin
            st <= C_IDLE;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end

  assign filtered.valid          = out_valid;
  assign filtered.total_filtered = out_total;
  assign filtered.ch1_filtered   = out_ch1;
  assign filtered.ch2_filtered   = out_ch2;
  assign filtered.ch1_spread     = out_sp1;
  assign filtered.ch2_spread     = out_sp2;
  assign filtered.filter_mode    = out_mode;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !samples.ready)
    else $error("sample taken while previous one still in the lanes");

  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_total == 25'(out_ch1) + 25'(out_ch2))
    else $error("total does not match the channel outputs");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_mode != MODE_UNUSED)
    else $error("unused mode code reached the output");

  a_primed_sticks: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed flag dropped without reset");
endmodule

/* dv/dlcaf_checker.sv */
// Checker for the dual load-cell adaptive filter: follows register writes and
// sample transfers, predicts each result and compares it with the result transfers.
// Depends on dlcaf_pkg and the two channel interfaces.
module dlcaf_checker
  import dlcaf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  dlcaf_in_if               samples,
  dlcaf_out_if              filtered,
  output int                errors,
  output int                pending
);

  typedef logic signed [SAMPLE_W-1:0] wt_t;

  typedef struct packed {
    logic signed [24:0] total;
    wt_t                ch1;
    wt_t                ch2;
    logic [23:0]        spread1;
    logic [23:0]        spread2;
    logic [1:0]         mode;
  } reading_t;

  logic [15:0] act_thr;
  logic [19:0] jump_thr;
  logic [30:0] quiet_to;

  wt_t         ring1 [16];
  wt_t         ring2 [16];
  logic [3:0]  ring_ptr;
  logic        primed;
  logic [1:0]  cur_mode;
  logic [31:0] last_act;
  wt_t         held1, held2;
  wt_t         hist1 [16];
  wt_t         hist2 [16];
  logic [3:0]  hist_ptr;
  int          hist_fill;

  reading_t expected_readings [$];

  assign pending = expected_readings.size();

  function automatic wt_t median_of(input wt_t r [16], input logic [3:0] ptr);
    wt_t buf_v [5];
    wt_t v;
    int  j;
    for (int i = 0; i < 5; i++) begin
      v = r[4'(ptr - 4'd1 - 4'(i))];
      j = i;
      while (j > 0 && buf_v[j-1] > v) begin
        buf_v[j] = buf_v[j-1];
        j--;
      end
      buf_v[j] = v;
    end
    return buf_v[2];
  endfunction

  function automatic wt_t mean_of(input wt_t r [16], input logic [3:0] ptr);
    longint s;
    s = 0;
    for (int i = 0; i < 8; i++) s += r[4'(ptr - 4'd1 - 4'(i))];
    // Signed division truncates toward zero, as the block does.
    return wt_t'(s / 8);
  endfunction

  function automatic logic [23:0] spread_of(input wt_t h [16], input int n);
    longint          s1;
    longint unsigned s2, a, b, num, v, r, bt;
    if (n < 2) return '0;
    s1 = 0;
    s2 = 0;
    for (int i = 0; i < n; i++) begin
      s1 += h[i];
      s2 += longint'(h[i]) * longint'(h[i]);
    end
    a = longint'(n) * s2;
    b = s1 < 0 ? -s1 : s1;
    b = b * b;
    num = a >= b ? a - b : 0;
    v = num / (longint'(n) * longint'(n - 1));
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r > 64'hFFFFFF ? 24'hFFFFFF : r[23:0];
  endfunction

  task automatic refill(input wt_t a, input wt_t b);
    for (int i = 0; i < 16; i++) begin
      ring1[i] = a;
      ring2[i] = b;
    end
    ring_ptr = '0;
  endtask

  task automatic filter_step(input wt_t c1, input wt_t c2, input logic [31:0] now,
                             output reading_t res);
    longint      diff, change;
    logic        active;
    logic [31:0] quiet;
    logic [23:0] sp1, sp2;
    sp1 = '0;
    sp2 = '0;
    if (!primed) begin
      refill(c1, c2);
      primed = 1'b1;
      held1 = c1;
      held2 = c2;
    end else begin
      diff = (longint'(c1) + longint'(c2)) - (longint'(held1) + longint'(held2));
      change = diff < 0 ? -diff : diff;
      active = change > longint'(act_thr);
      quiet = now - last_act;
      ring1[ring_ptr] = c1;
      ring2[ring_ptr] = c2;
      ring_ptr = ring_ptr + 4'd1;
      case (cur_mode)
        MODE_STABLE: begin
          if (active) begin
            cur_mode = MODE_BREWING;
            last_act = now;
          end
        end
        MODE_BREWING: begin
          if (active) last_act = now;
          else if (quiet > {1'b0, quiet_to}) cur_mode = MODE_TRANSITIONING;
        end
        default: begin
          if (active) begin
            cur_mode = MODE_BREWING;
            last_act = now;
          end else if (33'(quiet) > {1'b0, quiet_to, 1'b0}) begin
            cur_mode = MODE_STABLE;
          end
        end
      endcase
      if (cur_mode == MODE_BREWING) begin
        held1 = median_of(ring1, ring_ptr);
        held2 = median_of(ring2, ring_ptr);
      end else begin
        held1 = mean_of(ring1, ring_ptr);
        held2 = mean_of(ring2, ring_ptr);
      end
      if (change > longint'(jump_thr)) begin
        held1 = c1;
        held2 = c2;
        refill(c1, c2);
        if (cur_mode == MODE_STABLE) begin
          cur_mode = MODE_BREWING;
          last_act = now;
        end
      end
    end
    hist1[hist_ptr] = held1;
    hist2[hist_ptr] = held2;
    hist_ptr = hist_ptr + 4'd1;
    if (hist_fill < 16) hist_fill++;
    if (hist_fill > 1 && primed && !(hist_fill == 1)) begin
      sp1 = spread_of(hist1, hist_fill);
      sp2 = spread_of(hist2, hist_fill);
    end
    res.total   = 25'(held1) + 25'(held2);
    res.ch1     = held1;
    res.ch2     = held2;
    res.spread1 = sp1;
    res.spread2 = sp2;
    res.mode    = cur_mode;
  endtask

  always @(posedge clk) begin
    reading_t got, want;
    if (rst) begin
      act_thr   = ACTIVITY_RST;
      jump_thr  = JUMP_RST;
      quiet_to  = QUIET_RST;
      ring_ptr  = '0;
      primed    = 1'b0;
      cur_mode  = MODE_STABLE;
      last_act  = '0;
      held1     = '0;
      held2     = '0;
      hist_ptr  = '0;
      hist_fill = 0;
      errors    = 0;
      expected_readings.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_ACTIVITY: act_thr = cfg_data[15:0];
          CFG_JUMP:     jump_thr = cfg_data[19:0];
          CFG_QUIET:    quiet_to = cfg_data;
          default: ;
        endcase
      end
      if (filtered.valid && filtered.ready) begin
        got = '{filtered.total_filtered, filtered.ch1_filtered, filtered.ch2_filtered,
                filtered.ch1_spread, filtered.ch2_spread, filtered.filter_mode};
        if (expected_readings.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (got.total !== want.total) begin
            $error("total_filtered: expected %0d, got %0d", want.total, got.total);
            errors++;
          end
          if (got.ch1 !== want.ch1) begin
            $error("ch1_filtered: expected %0d, got %0d", want.ch1, got.ch1);
            errors++;
          end
          if (got.ch2 !== want.ch2) begin
            $error("ch2_filtered: expected %0d, got %0d", want.ch2, got.ch2);
            errors++;
          end
          if (got.spread1 !== want.spread1) begin
            $error("ch1_spread: expected %0d, got %0d", want.spread1, got.spread1);
            errors++;
          end
          if (got.spread2 !== want.spread2) begin
            $error("ch2_spread: expected %0d, got %0d", want.spread2, got.spread2);
            errors++;
          end
          if (got.mode !== want.mode) begin
            $error("filter_mode: expected %0d, got %0d", want.mode, got.mode);
            errors++;
          end
        end
      end
      if (samples.valid && samples.ready) begin
        filter_step(samples.ch1_weight, samples.ch2_weight, samples.now_ms, want);
        expected_readings.push_back(want);
      end
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top for the dual load-cell adaptive filter: clock, reset, register
// writes, sample stimulus with bursts and gaps, result stalls and the verdict.
// Depends on dlcaf_pkg, the channel interfaces, dlcaf_checker and the block.
module tb;
  import dlcaf_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_write_en;
  logic [1:0]        cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                errors;
  int                pending;
  int                stall_style;
  int                burst_left;
  logic [31:0]       now;
  int                lvl1, lvl2;

  dlcaf_in_if  samples ();
  dlcaf_out_if filtered ();

  dual_load_cell_adaptive_filter u_dut (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .samples (samples.sink), .filtered (filtered.source)
  );

  dlcaf_checker u_checker (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .samples, .filtered, .errors, .pending
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Each phase picks one of four receiver stall patterns by its number.
  always @(negedge clk) begin
    case (stall_style)
      0: filtered.ready <= 1'b1;
      1: filtered.ready <= $urandom_range(1, 0);
      2: filtered.ready <= ($urandom_range(7, 0) == 0);
      default: filtered.ready <= ($urandom_range(99, 0) < 3) ? 1'b0 : 1'b1;
    endcase
  end

  initial begin
    #60_000_000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = val;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Waits until every result has come, then lets the block settle.
  task automatic drain;
    @(negedge clk);
    samples.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic send(input int c1, input int c2, input logic [31:0] t);
    if (burst_left == 0) begin
      samples.valid = 1'b0;
      if ($urandom_range(9, 0) == 0) repeat ($urandom_range(300, 1)) @(negedge clk);
      else repeat ($urandom_range(4, 0)) @(negedge clk);
      burst_left = $urandom_range(20, 1);
    end
    samples.valid      = 1'b1;
    samples.ch1_weight = 24'(c1);
    samples.ch2_weight = 24'(c2);
    samples.now_ms     = t;
    do @(posedge clk); while (!samples.ready);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic int clip(input int v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic random_item;
    int k;
    k = $urandom_range(99, 0);
    if (k < 10) now += $urandom_range(3000, 400);
    else now += $urandom_range(120, 0);
    if (k < 70) begin
      lvl1 = clip(lvl1 + $urandom_range(4, 0) - 2);
    end else if (k < 85) begin
      lvl1 = clip(lvl1 + $urandom_range(3000, 0) - 1500);
      lvl2 = clip(lvl2 + $urandom_range(600, 0) - 300);
    end else if (k < 92) begin
      lvl1 = clip(lvl1 + $urandom_range(200000, 0) - 100000);
    end else if (k < 97) begin
      lvl1 = $signed(24'($urandom));
      lvl2 = $signed(24'($urandom));
    end else begin
      lvl1 = $urandom_range(1, 0) ? 8388607 : -8388608;
      lvl2 = $urandom_range(1, 0) ? 8388607 : -8388608;
    end
    send(clip(lvl1 + $urandom_range(30, 0) - 15), clip(lvl2 + $urandom_range(30, 0) - 15),
         ($urandom_range(199, 0) == 0) ? $urandom : now);
  endtask

  initial begin
    logic [CFG_DW-1:0] phase_cfg [5][3];
    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = CFG_ACTIVITY;
    cfg_data     = '0;
    samples.valid      = 1'b0;
    samples.ch1_weight = '0;
    samples.ch2_weight = '0;
    samples.now_ms     = '0;
    filtered.ready     = 1'b0;
    stall_style = 0;
    burst_left  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at reset settings: first sample passes through, extremes,
    // a jump, activity, quiet timeouts through transitioning to stable, and a
    // time stamp that wraps.
    now = 32'hFFFF_FF00;
    send(8388607, -8388608, now);
    send(-8388608, 8388607, now + 1);
    send(1000, 1000, now + 2);
    send(1030, 1040, now + 20);
    send(1100, 1100, now + 40);
    send(1110, 1100, now + 60);
    send(1110, 1105, now + 1500);
    send(1112, 1105, now + 1600);
    send(1112, 1106, now + 3700);
    send(1113, 1106, now + 3800);
    send(-8388608, -8388608, now + 3900);
    send(8388607, 8388607, now + 3950);
    send(0, 0, now + 4000);
    send(-1, 1, now + 4010);
    send(70, -5, now + 4020);
    now = now + 4020;
    lvl1 = 0;
    lvl2 = 0;
    drain();

    phase_cfg = '{'{31'd50, 31'd2000, 31'd1000},
                  '{31'd0, 31'd0, 31'd0},
                  '{31'd65535, 31'd1048575, 31'h7FFF_FFFF},
                  '{31'd20, 31'd500, 31'd200},
                  '{31'(16'($urandom)), 31'(20'($urandom)), 31'($urandom_range(3000, 0))}};
    for (int ph = 0; ph < 5; ph++) begin
      stall_style = ph % 4;
      write_reg(CFG_ACTIVITY, phase_cfg[ph][0]);
      write_reg(CFG_JUMP, phase_cfg[ph][1]);
      write_reg(CFG_QUIET, phase_cfg[ph][2]);
      for (int i = 0; i < 290; i++) random_item();
      drain();
    end

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
